/* hdl/ipv4_range_blocklist_core_macros.svh */
// Assertion macros for the IPv4 range blocklist core.
// Expects clk and arst_n in the scope of use.
`ifndef IPV4_RANGE_BLOCKLIST_CORE_MACROS_SVH
`define IPV4_RANGE_BLOCKLIST_CORE_MACROS_SVH

// same-cycle implication
`define IPV4RB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IPV4RB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/ipv4rb_pkg.sv */
// Types and codes shared by the IPv4 range blocklist core.
// No dependencies.
`default_nettype none
package ipv4rb_pkg;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_REVERSED = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOKUP,
		S_FIND,
		S_ABSORB,
		S_INSERT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [31:0] first;
		logic [31:0] last;
	} range_t;

	typedef struct packed {
		logic        shift_dn;
		logic        shift_up;
		range_t      w;
		logic [31:0] addr;
	} cell_ctrl_t;

	typedef struct packed {
		logic ovl;
		logic nb;
		logic ins;
		logic match;
	} cell_flags_t;

endpackage
`default_nettype wire

/* hdl/ipv4rb_if.sv */
// Channel interfaces: request, response and configuration write.
// Depends on nothing.
`default_nettype none
interface ipv4rb_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [31:0] range_begin;
	logic [31:0] range_end;
	logic [31:0] lookup_addr;
	logic        addr_is_v6;
	modport source (output valid, cmd, range_begin, range_end, lookup_addr, addr_is_v6,
		input ready);
	modport sink (input valid, cmd, range_begin, range_end, lookup_addr, addr_is_v6,
		output ready);
endinterface

interface ipv4rb_rsp_if;
	logic       valid;
	logic       ready;
	logic       hit;
	logic [1:0] status;
	logic [8:0] rule_count;
	modport source (output valid, hit, status, rule_count, input ready);
	modport sink (input valid, hit, status, rule_count, output ready);
endinterface

interface ipv4rb_cfg_if;
	logic valid;
	logic ready;
	logic data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

/* hdl/ipv4rb_cell.sv */
// One table cell: holds a range, compares it, shifts to/from neighbours.
// Depends on ipv4rb_pkg.
`default_nettype none
module ipv4rb_cell
	import ipv4rb_pkg::*;
(
	input  wire logic        clk,
	input  wire cell_ctrl_t  ctrl,
	input  wire logic        valid,
	input  wire logic        prev_ins,
	input  wire range_t      prev_rng,
	input  wire range_t      next_rng,
	output range_t           rng,
	output cell_flags_t      flags
);
	range_t rng_q;

	assign rng = rng_q;

	always_comb begin
		flags.ovl   = valid && (rng_q.first <= ctrl.w.last) && (rng_q.last >= ctrl.w.first);
		flags.nb    = !valid || (rng_q.last >= ctrl.w.first);
		flags.ins   = !valid || (rng_q.first > ctrl.w.last);
		flags.match = valid && (rng_q.first <= ctrl.addr) && (ctrl.addr <= rng_q.last);
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift_dn && flags.nb) begin
			rng_q <= next_rng;
		end else if (ctrl.shift_up && flags.ins) begin
			rng_q <= prev_ins ? prev_rng : ctrl.w;
		end
	end
endmodule
`default_nettype wire

/* hdl/ipv4_range_blocklist_core.sv */
// Lookup: S_LOOKUP, then S_DONE loads the registered response; all cells compare at once.
// Add: S_FIND, then S_ABSORB and S_FIND again per stored range merged, then S_INSERT.
// Rejected as full: S_FIND to S_DONE. Reversed add, clear and unused command: S_DONE only.
// Next request is accepted the cycle after the response loads; one request at a time.
// Reset: rule count 0, enabled 1; cell contents are left as they are, no clearing pass.
// Depends on ipv4rb_pkg, ipv4rb_if, ipv4rb_cell and the assertion macros header.
`default_nettype none
`include "ipv4_range_blocklist_core_macros.svh"
module ipv4_range_blocklist_core
	import ipv4rb_pkg::*;
#(
	parameter int MAX_RANGES = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ipv4rb_req_if.sink   req,
	ipv4rb_rsp_if.source rsp,
	ipv4rb_cfg_if.sink   cfg
);
	localparam int CW = $clog2(MAX_RANGES + 1);

	state_t         state_q, state_d;
	cell_ctrl_t     ctrl;
	range_t         rng [MAX_RANGES];
	cell_flags_t    flg [MAX_RANGES];
	range_t         sel;
	logic           any_ovl, any_match;

	logic [CW-1:0]  count_q;
	logic           enabled_q;
	logic           res_hit_q;
	status_t        res_status_q;
	range_t         w_q, sel_q;
	logic [31:0]    addr_q;
	logic           v6_q;
	logic           out_valid_q, out_hit_q;
	logic [1:0]     out_status_q;
	logic [8:0]     out_count_q;
	logic           out_load;

	for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
		ipv4rb_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.valid    (CW'(i) < count_q),
			.prev_ins ((i == 0) ? 1'b0 : flg[(i == 0) ? 0 : i-1].ins),
			.prev_rng ((i == 0) ? range_t'('0) : rng[(i == 0) ? 0 : i-1]),
			.next_rng ((i == MAX_RANGES-1) ? range_t'('0)
				: rng[(i == MAX_RANGES-1) ? i : i+1]),
			.rng      (rng[i]),
			.flags    (flg[i])
		);
	end

	always_comb begin
		sel       = '0;
		any_ovl   = 1'b0;
		any_match = 1'b0;
		for (int j = 0; j < MAX_RANGES; j++) begin
			if (flg[j].ovl && (j == 0 || !flg[(j == 0) ? 0 : j-1].ovl)) begin
				sel = sel | rng[j];
			end
			any_ovl   = any_ovl | flg[j].ovl;
			any_match = any_match | flg[j].match;
		end
	end

	always_comb begin
		state_d       = state_q;
		ctrl.shift_dn = 1'b0;
		ctrl.shift_up = 1'b0;
		ctrl.w        = w_q;
		ctrl.addr     = addr_q;
		req.ready     = (state_q == S_IDLE);
		out_load      = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					case (cmd_t'(req.cmd))
						CMD_ADD:    state_d = (req.range_begin > req.range_end) ? S_DONE : S_FIND;
						CMD_LOOKUP: state_d = S_LOOKUP;
						default:    state_d = S_DONE;
					endcase
				end
			end
			S_LOOKUP: state_d = S_DONE;
			S_FIND: begin
				if (any_ovl) begin
					state_d = S_ABSORB;
				end else if (count_q == CW'(MAX_RANGES)) begin
					state_d = S_DONE;
				end else begin
					state_d = S_INSERT;
				end
			end
			S_ABSORB: begin
				ctrl.shift_dn = 1'b1;
				state_d       = S_FIND;
			end
			S_INSERT: begin
				ctrl.shift_up = 1'b1;
				state_d       = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			enabled_q    <= 1'b1;
			out_valid_q  <= 1'b0;
			res_hit_q    <= 1'b0;
			res_status_q <= ST_OK;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				enabled_q <= cfg.data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						res_hit_q    <= 1'b0;
						res_status_q <= ST_OK;
						if (cmd_t'(req.cmd) == CMD_CLEAR) begin
							count_q <= '0;
						end
						if (cmd_t'(req.cmd) == CMD_ADD && req.range_begin > req.range_end) begin
							res_status_q <= ST_REVERSED;
						end
					end
				end
				S_LOOKUP: res_hit_q <= enabled_q && !v6_q && any_match;
				S_FIND: begin
					if (!any_ovl && count_q == CW'(MAX_RANGES)) begin
						res_status_q <= ST_FULL;
					end
				end
				S_ABSORB: count_q <= count_q - 1'b1;
				S_INSERT: count_q <= count_q + 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			w_q    <= '{first: req.range_begin, last: req.range_end};
			addr_q <= req.lookup_addr;
			v6_q   <= req.addr_is_v6;
		end
		if (state_q == S_FIND) begin
			sel_q <= sel;
		end
		if (state_q == S_ABSORB) begin
			w_q.first <= (sel_q.first < w_q.first) ? sel_q.first : w_q.first;
			w_q.last  <= (sel_q.last > w_q.last) ? sel_q.last : w_q.last;
		end
		if (out_load) begin
			out_hit_q    <= res_hit_q;
			out_status_q <= res_status_q;
			out_count_q  <= 9'(count_q);
		end
	end

	assign cfg.ready      = 1'b1;
	assign rsp.valid      = out_valid_q;
	assign rsp.hit        = out_hit_q;
	assign rsp.status     = out_status_q;
	assign rsp.rule_count = out_count_q;

	`IPV4RB_ASSERT_NOW(a_count_max, 1'b1, count_q <= CW'(MAX_RANGES), "rule count above capacity")
	`IPV4RB_ASSERT_NEXT(a_absorb_dec, state_q == S_ABSORB, count_q == $past(count_q) - 1'b1, "merge did not drop one range")
	`IPV4RB_ASSERT_NEXT(a_insert_inc, state_q == S_INSERT, count_q == $past(count_q) + 1'b1, "insert did not add one range")
	`IPV4RB_ASSERT_NOW(a_full_nomerge, state_q == S_INSERT, count_q < CW'(MAX_RANGES), "insert into a full table")
endmodule
`default_nettype wire

/* verif/tb_top.sv */
// Testbench for ipv4_range_blocklist_core: directed and random add/lookup/clear/no-op traffic,
// checked against an in-bench range table model. Depends on ipv4rb_pkg, ipv4rb_if and the core.
`timescale 1ns / 1ps
module tb_top;
	import ipv4rb_pkg::*;

	typedef struct packed {
		logic       hit;
		logic [1:0] status;
		logic [8:0] rule_count;
	} answer_t;

	int  mismatches = 0;

	task automatic report_mismatch(string what, longint exp_v, longint got_v);
		$display("mismatch %s: expected %0h got %0h at %0t", what, exp_v, got_v, $realtime);
		mismatches++;
	endtask

	class blocklist_scoreboard;
		logic [31:0] first_q[$];
		logic [31:0] last_q[$];
		bit          enabled;
		answer_t     pending[$];

		function new();
			enabled = 1;
		endfunction

		function void note_request(logic [1:0] cmd, logic [31:0] rb, logic [31:0] re,
				logic [31:0] addr, logic v6);
			answer_t a;
			int lo, hi, n;
			logic [31:0] nb, ne;
			a = '0;
			n = first_q.size();
			if (cmd == CMD_ADD) begin
				if (rb > re) begin
					a.status = ST_REVERSED;
				end else begin
					lo = 0;
					while (lo < n && last_q[lo] < rb) lo++;
					hi = lo;
					while (hi < n && first_q[hi] <= re) hi++;
					if (n - (hi - lo) + 1 > 256) begin
						a.status = ST_FULL;
					end else begin
						nb = rb;
						ne = re;
						if (hi > lo) begin
							if (first_q[lo] < nb) nb = first_q[lo];
							if (last_q[hi-1] > ne) ne = last_q[hi-1];
						end
						for (int k = hi - 1; k >= lo; k--) begin
							first_q.delete(k);
							last_q.delete(k);
						end
						first_q.insert(lo, nb);
						last_q.insert(lo, ne);
					end
				end
			end else if (cmd == CMD_LOOKUP) begin
				if (enabled && !v6)
					foreach (first_q[k])
						if (addr >= first_q[k] && addr <= last_q[k]) a.hit = 1'b1;
			end else if (cmd == CMD_CLEAR) begin
				first_q.delete();
				last_q.delete();
			end
			a.rule_count = 9'(first_q.size());
			pending.push_back(a);
		endfunction

		task check_answer(answer_t got);
			answer_t e;
			if (pending.size() == 0) begin
				report_mismatch("response with nothing expected", 0, got);
				return;
			end
			e = pending.pop_front();
			if (got.hit !== e.hit) report_mismatch("hit", e.hit, got.hit);
			if (got.status !== e.status) report_mismatch("status", e.status, got.status);
			if (got.rule_count !== e.rule_count)
				report_mismatch("rule_count", e.rule_count, got.rule_count);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	always #5 clk = ~clk;

	ipv4rb_req_if req();
	ipv4rb_rsp_if rsp();
	ipv4rb_cfg_if cfg();

	ipv4_range_blocklist_core i_dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cfg(cfg));

	blocklist_scoreboard sb = new();
	int  long_hold = 0;

	function automatic int gap_len();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
	endfunction

	initial begin
		req.valid = 0; req.cmd = 0; req.range_begin = 0; req.range_end = 0;
		req.lookup_addr = 0; req.addr_is_v6 = 0;
		cfg.valid = 0; cfg.data = 0;
		rsp.ready = 0;
	end

	// response side: random stalls plus a long hold-off requested by the sender
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_answer({rsp.hit, rsp.status, rsp.rule_count});
		if (long_hold > 0) begin
			long_hold <= long_hold - 1;
			rsp.ready <= 0;
		end else begin
			rsp.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	task automatic send(logic [1:0] cmd, logic [31:0] rb, logic [31:0] re, logic [31:0] addr,
			logic v6, bit nogap = 0);
		int g;
		g = nogap ? 0 : gap_len();
		repeat (g) @(posedge clk);
		req.valid <= 1;
		req.cmd <= cmd;
		req.range_begin <= rb;
		req.range_end <= re;
		req.lookup_addr <= addr;
		req.addr_is_v6 <= v6;
		do @(posedge clk); while (!req.ready);
		sb.note_request(cmd, rb, re, addr, v6);
		req.valid <= 0;
		// block is busy for at least this cycle after a transaction
		@(posedge clk);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_enable(bit v);
		drain();
		cfg.valid <= 1;
		cfg.data <= v;
		do @(posedge clk); while (!cfg.ready);
		sb.enabled = v;
		cfg.valid <= 0;
	endtask

	function automatic logic [31:0] rnd32();
		return $urandom();
	endfunction

	task automatic random_item(logic [31:0] base, int span);
		int p;
		logic [31:0] b, w;
		p = $urandom_range(0, 99);
		b = base + $urandom_range(0, span);
		w = $urandom_range(0, 40);
		if (p < 40) send(CMD_ADD, b, b + w, 0, 0);
		else if (p < 85) send(CMD_LOOKUP, rnd32(), rnd32(), base + $urandom_range(0, span + 50),
			$urandom_range(0, 7) == 0);
		else if (p < 89) send(CMD_CLEAR, rnd32(), rnd32(), rnd32(), 1'($urandom_range(0, 1)));
		else if (p < 92) send(CMD_NONE, rnd32(), rnd32(), rnd32(), 1'($urandom_range(0, 1)));
		else if (p < 95) send(CMD_ADD, rnd32(), rnd32(), rnd32(), 1'($urandom_range(0, 1)));
		else send(CMD_LOOKUP, 0, 0, rnd32(), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed
		send(CMD_LOOKUP, 0, 0, 32'h0A000001, 0);
		send(CMD_ADD, 32'h0A000000, 32'h0A0000FF, 0, 0);
		send(CMD_ADD, 32'h0A000100, 32'h0A0001FF, 0, 0);
		send(CMD_ADD, 32'h0A000050, 32'h0A000150, 0, 0);
		send(CMD_ADD, 32'h20, 32'h10, 0, 0);
		send(CMD_ADD, 32'h0, 32'h0, 0, 0);
		send(CMD_ADD, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0);
		send(CMD_ADD, 32'hFFFFFFFF, 32'h0, 0, 0);
		send(CMD_LOOKUP, 0, 0, 32'h0, 0);
		send(CMD_LOOKUP, 0, 0, 32'hFFFFFFFF, 0);
		send(CMD_LOOKUP, 0, 0, 32'h0A000150, 1);
		send(CMD_LOOKUP, 0, 0, 32'h0A000200, 0);
		send(CMD_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1);
		send(CMD_ADD, 32'h0, 32'hFFFFFFFF, 0, 0);
		send(CMD_LOOKUP, 0, 0, 32'h12345678, 0);
		write_enable(0);
		send(CMD_LOOKUP, 0, 0, 32'h12345678, 0);
		write_enable(1);
		send(CMD_CLEAR, 0, 0, 0, 0);
		send(CMD_LOOKUP, 0, 0, 32'h0, 0);
		// fill the table to capacity; the loop's last add and one more disjoint add are rejected
		for (int k = 0; k < 257; k++) send(CMD_ADD, k * 4, k * 4 + 1, 0, 0, 1);
		send(CMD_ADD, 32'h1000, 32'h1000, 0, 0);
		send(CMD_ADD, 0, 32'h10, 0, 0);
		send(CMD_LOOKUP, 0, 0, 32'h3FD, 0);
		// sender pauses until all answers are back
		drain();
		// receiver hold-off while requests keep coming
		long_hold = 300;
		for (int k = 0; k < 10; k++) send(CMD_LOOKUP, 0, 0, k * 4, 0, 1);
		send(CMD_CLEAR, 0, 0, 0, 0);
		// random phases
		for (int ph = 0; ph < 5; ph++) begin
			logic [31:0] base;
			base = (ph == 4) ? 32'hFFFFFE00 : rnd32();
			if (ph == 2) write_enable(0);
			if (ph == 3) write_enable(1);
			for (int k = 0; k < 290; k++) random_item(base, (ph == 1) ? 20000 : 400);
		end
		drain();
		if (mismatches == 0 && sb.pending.size() == 0) $display("** ipv4_range_blocklist_core: PASSED **");
		else $display("** ipv4_range_blocklist_core: FAILED **");
		$finish;
	end

	initial begin
		#20ms;
		$display("** ipv4_range_blocklist_core: FAILED **");
		$finish;
	end
endmodule

/* files.f */
+incdir+hdl
hdl/ipv4rb_pkg.sv
hdl/ipv4rb_if.sv
hdl/ipv4rb_cell.sv
hdl/ipv4_range_blocklist_core.sv
verif/tb_top.sv
